// ----- design/cbf_pkg.sv -----
package cbf_pkg;

    // Filter capacity and derived widths
    localparam int MAX_BITS = 256;
    localparam int IDX_W    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int CODE_W   = 8;
    localparam int SIZE_W   = 9;
    localparam int CNT_W    = $clog2(CODE_W + 1);
    localparam int CMP_W    = (SIZE_W > $clog2(MAX_BITS + 1)) ? SIZE_W : $clog2(MAX_BITS + 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(255);

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Filter store command
    typedef struct packed {
        logic             set;
        logic [IDX_W-1:0] idx;
    } store_cmd_t;

    // Size in use: zero acts as one, clamp to capacity
    function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] s);
        logic [CMP_W-1:0] s_ext;
        logic [SIZE_W-1:0] r;
        s_ext = CMP_W'(s);
        r     = s;
        if (s == '0)
            r = SIZE_W'(1);
        else if (s_ext > CMP_W'(MAX_BITS))
            r = SIZE_W'(MAX_BITS);
        return r;
    endfunction

endpackage

// ----- design/cbf_if.sv -----
// Input channel: one character per transfer, last marks the end of a word
interface cbf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [cbf_pkg::CODE_W-1:0]  char_code;
    logic                        last;

    modport source (output valid, output operation, output char_code, output last,
                    input ready);
    modport sink   (input valid, input operation, input char_code, input last,
                    output ready);
endinterface

// Output channel: membership result
interface cbf_out_if;
    logic valid;
    logic ready;
    logic present;

    modport source (output valid, output present, input ready);
    modport sink   (input valid, input present, output ready);
endinterface

// ----- design/cbf_mod_unit.sv -----
// Restoring remainder unit: one dividend bit per cycle
module cbf_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cbf_pkg::div_ctrl_t          ctrl,
    input  logic [cbf_pkg::CODE_W-1:0]  dividend,
    input  logic [cbf_pkg::SIZE_W-1:0]  divisor,
    output logic [cbf_pkg::SIZE_W-1:0]  remainder,
    output cbf_pkg::div_stat_t          stat
);

    logic [cbf_pkg::CODE_W-1:0] dvd_reg, dvd_next;
    logic [cbf_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic [cbf_pkg::SIZE_W-1:0] dsr_reg, dsr_next;
    logic [cbf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cbf_pkg::SIZE_W:0]   trial;
    logic [cbf_pkg::SIZE_W:0]   diff;

    // Shift in next bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[cbf_pkg::CODE_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (ctrl.start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = cbf_pkg::CNT_W'(cbf_pkg::CODE_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[cbf_pkg::CODE_W-2:0], 1'b0};
            // trial < 2*divisor, so the result stays below divisor
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[cbf_pkg::SIZE_W-1:0];
            else
                rem_next = trial[cbf_pkg::SIZE_W-1:0];
            cnt_next = cnt_reg - cbf_pkg::CNT_W'(1);
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = (cnt_reg == '0);

    // Remainder stays below the divisor once finished
    a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cnt_reg) == cbf_pkg::CNT_W'(1) && !$past(ctrl.start)) |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");

endmodule

// ----- design/cbf_filter_store.sv -----
// Filter bit array: cleared by a pass after reset, one bit set per insert,
// read registered at the command index
module cbf_filter_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cbf_pkg::store_cmd_t         cmd,
    output logic                        rd_bit,
    output logic                        clearing
);

    logic                        mem [cbf_pkg::MAX_BITS];
    logic [cbf_pkg::IDX_W-1:0]   clr_idx_reg;
    logic                        clr_busy_reg;
    logic                        rd_bit_reg;

    // Clearing pass, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + cbf_pkg::IDX_W'(1);
            if (clr_idx_reg == cbf_pkg::IDX_W'(cbf_pkg::MAX_BITS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // Bit write and registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_idx_reg] <= 1'b0;
        else if (cmd.set)
            mem[cmd.idx] <= 1'b1;
        rd_bit_reg <= mem[cmd.idx];
    end

    assign rd_bit   = rd_bit_reg;
    assign clearing = clr_busy_reg;

    // No insert lands while the clearing pass runs
    a_no_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !cmd.set)
        else $error("filter bit set during clearing pass");

endmodule

// ----- design/char_bloom_filter.sv -----
// Character Bloom filter, single modulo hash.
// Each character runs the remainder steps, then the filter bit read, then the update.
// in_ch.ready is low while a character is in work; the next one is taken only after it is done.
// A check that ends a word waits in the read state while the previous result is not taken.
// Reset (rst_n low, async): match flag one, filter_size 255; the filter bits are then
// cleared in a pass, one bit per cycle, with in_ch.ready low.
module char_bloom_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cbf_pkg::SIZE_W-1:0]  cfg_wdata,
    cbf_in_if.sink                      in_ch,
    cbf_out_if.source                   out_ch
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ} state_t;

    state_t                     state_reg, state_next;
    logic [cbf_pkg::SIZE_W-1:0] size_reg;
    logic                       op_reg, op_next;
    logic                       last_reg, last_next;
    logic                       match_reg, match_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       present_reg, present_next;

    cbf_pkg::div_ctrl_t         div_ctrl;
    cbf_pkg::div_stat_t         div_stat;
    cbf_pkg::store_cmd_t        st_cmd;
    logic [cbf_pkg::SIZE_W-1:0] rem;
    logic                       rd_bit;
    logic                       clearing;
    logic                       accept;
    logic                       update;
    logic                       emit;
    logic                       out_free;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= cbf_pkg::SIZE_RESET;
        else if (cfg_we)
            size_reg <= cfg_wdata;
    end

    cbf_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (in_ch.char_code),
        .divisor   (cbf_pkg::effective_size(size_reg)),
        .remainder (rem),
        .stat      (div_stat)
    );

    cbf_filter_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (st_cmd),
        .rd_bit   (rd_bit),
        .clearing (clearing)
    );

    // Handshake and update qualifiers
    assign in_ch.ready    = (state_reg == S_IDLE) && !clearing;
    assign accept         = in_ch.valid && in_ch.ready;
    assign out_free       = !out_valid_reg || out_ch.ready;
    assign emit           = (op_reg == cbf_pkg::OP_CHECK) && last_reg;
    assign update         = (state_reg == S_READ) && (out_free || !emit);
    assign div_ctrl.start = accept;
    assign st_cmd.idx     = cbf_pkg::IDX_W'(rem);
    assign st_cmd.set     = update && (op_reg == cbf_pkg::OP_INSERT);

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        present_next   = present_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_ch.operation;
                    last_next  = in_ch.last;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // remainder final, its bit is read at this edge
                if (div_stat.done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (update)
                begin
                    state_next = S_IDLE;
                    if (op_reg == cbf_pkg::OP_CHECK)
                    begin
                        if (last_reg)
                        begin
                            present_next   = match_reg & rd_bit;
                            out_valid_next = 1'b1;
                            match_next     = 1'b1;
                        end
                        else
                            match_next = match_reg & rd_bit;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            match_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            op_reg        <= cbf_pkg::OP_INSERT;
            last_reg      <= 1'b0;
            present_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            present_reg   <= present_next;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.present = present_reg;

    // Divider cannot report done right after a start
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !div_stat.done)
        else $error("remainder finished too early");

    // Filter bits are set only by a finished insert
    a_set_insert: assert property (@(posedge clk) disable iff (!rst_n)
        st_cmd.set |-> (state_reg == S_READ && op_reg == cbf_pkg::OP_INSERT))
        else $error("filter bit set outside an insert update");

    // A fresh result follows a check of a last character
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(update && emit))
        else $error("result without a last check character");

    // Match flag re-arms after each emitted result
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (update && emit) |=> match_reg)
        else $error("match flag not re-armed");

endmodule
